>>> hdl/lr_pkg.sv
package lr_pkg;

    // coordinate storage width inside the rasterizer
    localparam int COORD_BITS = 16;

    // fixed widths of the transaction fields
    localparam int IN_BITS    = 15;
    localparam int SUM_BITS   = IN_BITS + 1;
    localparam int OUT_BITS   = 16;
    localparam int COLOR_BITS = 32;
    localparam int ERR_BITS   = 18;
    localparam int STEP_BITS  = 2;

    // widest of the coordinate forms, used for sign extension
    localparam int WIDE_BITS = (COORD_BITS > SUM_BITS) ?
        ((COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS) :
        ((SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS);

    // mode codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef logic signed [IN_BITS-1:0]    t_in_coord;
    typedef logic signed [SUM_BITS-1:0]   t_sum;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [OUT_BITS-1:0]   t_out_coord;
    typedef logic        [SUM_BITS-1:0]   t_delta;
    typedef logic        [ERR_BITS-1:0]   t_err;
    typedef logic signed [STEP_BITS-1:0]  t_step;
    typedef logic        [COLOR_BITS-1:0] t_color;

    // line set up by a load transaction
    typedef struct packed {
        t_coord cur_x;
        t_coord cur_y;
        t_coord end_major;
        t_delta major_delta;
        t_delta minor_delta;
        t_step  step_x;
        t_step  step_y;
        logic   x_major;
        t_color color;
    } t_line;

    // one emitted pixel
    typedef struct packed {
        logic       valid;
        t_out_coord x;
        t_out_coord y;
        t_color     color;
        logic       last;
    } t_pixel;

    // wrap an exact endpoint into coordinate storage
    function automatic t_coord coord_from_sum(input t_sum v);
        logic signed [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return t_coord'(w[COORD_BITS-1:0]);
    endfunction

    // sign extend or cut a stored coordinate to the output width
    function automatic t_out_coord coord_to_out(input t_coord v);
        logic signed [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return t_out_coord'(w[OUT_BITS-1:0]);
    endfunction

    // direction of a signed difference
    function automatic t_step sign_of(input t_sum v);
        t_step s;
        if (v == '0) begin
            s = t_step'(0);
        end else if (v[SUM_BITS-1]) begin
            s = t_step'(-1);
        end else begin
            s = t_step'(1);
        end
        return s;
    endfunction

endpackage

>>> hdl/lr_setup.sv
module lr_setup
    import lr_pkg::*;
(
    input  t_in_coord i_begin_x,
    input  t_in_coord i_begin_y,
    input  t_in_coord i_vec_x,
    input  t_in_coord i_vec_y,
    input  t_color    i_pen_color,
    output t_line     o_line
);

    t_sum   p0x, p0y, p1x, p1y;
    t_sum   vx, vy;
    t_sum   dir_x, dir_y;
    t_delta adx, ady;
    logic   x_major;
    logic   swap;

    // exact endpoints and absolute deltas
    always_comb begin
        p0x = SUM_BITS'(i_begin_x);
        p0y = SUM_BITS'(i_begin_y);
        vx  = SUM_BITS'(i_vec_x);
        vy  = SUM_BITS'(i_vec_y);
        p1x = p0x + vx;
        p1y = p0y + vy;
        adx = vx[SUM_BITS-1] ? t_delta'(-vx) : t_delta'(vx);
        ady = vy[SUM_BITS-1] ? t_delta'(-vy) : t_delta'(vy);
    end

    // major axis pick and endpoint swap for x-major lines
    always_comb begin
        x_major = (adx >= ady);
        swap    = x_major && ((p0x > p1x) || (p0y < p1y));
        dir_x   = swap ? -vx : vx;
        dir_y   = swap ? -vy : vy;
    end

    // line parameters handed to the stepper
    always_comb begin
        o_line.cur_x       = coord_from_sum(swap ? p1x : p0x);
        o_line.cur_y       = coord_from_sum(swap ? p1y : p0y);
        if (x_major) begin
            o_line.end_major   = coord_from_sum(swap ? p0x : p1x);
            o_line.major_delta = adx;
            o_line.minor_delta = ady;
        end else begin
            o_line.end_major   = coord_from_sum(p1y);
            o_line.major_delta = ady;
            o_line.minor_delta = adx;
        end
        o_line.step_x  = sign_of(dir_x);
        o_line.step_y  = sign_of(dir_y);
        o_line.x_major = x_major;
        o_line.color   = i_pen_color;
    end

endmodule

>>> hdl/lr_stepper.sv
module lr_stepper
    import lr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_advance,
    input  logic   i_mode,
    input  t_line  i_line,
    output t_pixel o_pixel
);

    t_coord r_cur_x, r_cur_y, r_end_major;
    t_delta r_major_delta, r_minor_delta;
    t_err   r_err;
    t_step  r_step_x, r_step_y;
    logic   r_x_major, r_busy;
    t_color r_color;

    t_coord n_cur_x, n_cur_y;
    t_err   n_err;
    logic   n_busy;

    t_err   err_sum;
    t_err   thresh;
    logic   minor_step;
    logic   last;
    logic   emit;

    // end test and error term update
    always_comb begin
        last       = ((r_x_major ? r_cur_x : r_cur_y) == r_end_major);
        err_sum    = r_err + ERR_BITS'(r_minor_delta) + t_err'(1);
        thresh     = ERR_BITS'(r_major_delta) + t_err'(1);
        minor_step = (err_sum >= thresh);
        emit       = i_advance && (i_mode == MODE_STEP) && r_busy;
    end

    // next position after this pixel
    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_err   = r_err;
        n_busy  = r_busy;
        if (last) begin
            n_busy = 1'b0;
        end else begin
            n_err = minor_step ? (err_sum - thresh) : err_sum;
            if (r_x_major) begin
                n_cur_x = r_cur_x + COORD_BITS'(r_step_x);
                if (minor_step) begin
                    n_cur_y = r_cur_y + COORD_BITS'(r_step_y);
                end
            end else begin
                n_cur_y = r_cur_y + COORD_BITS'(r_step_y);
                if (minor_step) begin
                    n_cur_x = r_cur_x + COORD_BITS'(r_step_x);
                end
            end
        end
    end

    // line state: load replaces, step advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_end_major   <= '0;
            r_major_delta <= '0;
            r_minor_delta <= '0;
            r_err         <= '0;
            r_step_x      <= '0;
            r_step_y      <= '0;
            r_x_major     <= 1'b0;
            r_busy        <= 1'b0;
            r_color       <= '0;
        end else if (i_advance && (i_mode == MODE_LOAD)) begin
            r_cur_x       <= i_line.cur_x;
            r_cur_y       <= i_line.cur_y;
            r_end_major   <= i_line.end_major;
            r_major_delta <= i_line.major_delta;
            r_minor_delta <= i_line.minor_delta;
            r_err         <= '0;
            r_step_x      <= i_line.step_x;
            r_step_y      <= i_line.step_y;
            r_x_major     <= i_line.x_major;
            r_busy        <= 1'b1;
            r_color       <= i_line.color;
        end else if (emit) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
            r_busy  <= n_busy;
        end
    end

    // pixel for the output register
    always_comb begin
        o_pixel.valid = emit;
        o_pixel.x     = coord_to_out(r_cur_x);
        o_pixel.y     = coord_to_out(r_cur_y);
        o_pixel.color = r_color;
        o_pixel.last  = last;
    end

endmodule

>>> hdl/line_rasterizer_top.sv
// line rasterizer: one pixel per step transaction while a line is active
// path: an accepted transaction is held in the input register, and its pixel
// is registered in the output register and shown on the outputs from there
// throughput: one transaction per cycle while the output is not stalled
// reset: synchronous active low, clears the line state so the block is idle
module line_rasterizer_top
    import lr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_mode,
    input  t_in_coord  i_begin_x,
    input  t_in_coord  i_begin_y,
    input  t_in_coord  i_vec_x,
    input  t_in_coord  i_vec_y,
    input  t_color     i_pen_color,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_coord o_pixel_x,
    output t_out_coord o_pixel_y,
    output t_color     o_pixel_color,
    output logic       o_last
);

    logic      r_in_valid;
    logic      r_mode;
    t_in_coord r_begin_x, r_begin_y, r_vec_x, r_vec_y;
    t_color    r_pen_color;

    logic      r_out_valid;
    t_pixel    r_pixel;

    logic      out_free;
    logic      advance;
    t_line     line;
    t_pixel    pixel;

    // handshake between the two register stages
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        advance    = r_in_valid && out_free;
        o_in_stall = r_in_valid && !out_free;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_mode      <= i_mode;
            r_begin_x   <= i_begin_x;
            r_begin_y   <= i_begin_y;
            r_vec_x     <= i_vec_x;
            r_vec_y     <= i_vec_y;
            r_pen_color <= i_pen_color;
        end
    end

    lr_setup u_setup (
        .i_begin_x   (r_begin_x),
        .i_begin_y   (r_begin_y),
        .i_vec_x     (r_vec_x),
        .i_vec_y     (r_vec_y),
        .i_pen_color (r_pen_color),
        .o_line      (line)
    );

    lr_stepper u_stepper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_mode    (r_mode),
        .i_line    (line),
        .o_pixel   (pixel)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= pixel.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && pixel.valid) begin
            r_pixel <= pixel;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_pixel.x;
    assign o_pixel_y     = r_pixel.y;
    assign o_pixel_color = r_pixel.color;
    assign o_last        = r_pixel.last;

endmodule
